// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker modules of the core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal holds its value in the cycle after cond.
`define ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ----- rtl/core/stcl_pkg.sv -----
// Types and constants of the sampled tone curve interpolator.
// No dependencies; used by the top level and its checker.
package stcl_pkg;

	localparam int unsigned CNT_W     = 13;  // entry_count register
	localparam int unsigned IDX_W     = 12;  // table_index
	localparam int unsigned SMP_W     = 16;  // table_sample
	localparam int unsigned VAL_W     = 16;  // x_in and y_out
	localparam int unsigned S_TDATA_W = 48;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned CFG_AW    = 3;

	// slave tdata field positions
	localparam int unsigned IDX_LSB = 0;
	localparam int unsigned SMP_LSB = IDX_LSB + IDX_W;
	localparam int unsigned X_LSB   = SMP_LSB + SMP_W;

	// slave tuser bit positions
	localparam int unsigned CMD_BIT = 0;
	localparam int unsigned PCS_BIT = 1;

	localparam logic [VAL_W-1:0] ONE_U115 = 16'h8000;
	localparam logic [VAL_W-1:0] MAX_U16  = 16'hFFFF;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MAP  = 1'b1
	} cmd_t;

	// register word index (paddr above the byte lane bits)
	typedef enum logic {
		REG_ENTRY_COUNT = 1'b0
	} cfg_reg_t;

endpackage

// ----- rtl/core/sampled_tone_curve_lerp.sv -----
// Sampled tone curve with linear interpolation: table loads and u1.15 maps.
// Depends on stcl_pkg; table kept in a dual-read synchronous memory.
//
//   channel   dir  transaction              payload
//   s_*       in   load or map item         tdata index/sample/x, tuser command/pcs
//   m_*       out  mapped value (maps only) tdata y_out
//   APB       in   entry_count write/read   pwdata[12:0] at word 0
//
// One item per clock while m_tready is high. A map result passes stage 1
// (position), stage 2 (table read, blend), stage 3 (round), stage 4 (rescale)
// and the output register before it shows on m_tvalid; the position multiply
// sits ahead of stage 1. A load writes the table as it leaves stage 1, in item
// order with the reads of later maps. A stalled output halts the whole pipeline.
// Reset clears entry_count and the pipeline valids; table contents are kept.
module sampled_tone_curve_lerp
	import stcl_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_AW-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // table_index, table_sample, x_in, zero pad
	input  logic [S_TUSER_W-1:0]  s_tuser,  // command, pcs_xyz
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [VAL_W-1:0]      m_tdata   // y_out
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT =
		(MAX_ENTRIES >= (1 << CNT_W)) ? {CNT_W{1'b1}} : CNT_W'(MAX_ENTRIES);

	localparam int unsigned CRD_W = VAL_W + CNT_W;  // x * last
	localparam int unsigned FRC_W = 15;
	localparam int unsigned POS_W = CRD_W - FRC_W;

	// configuration
	logic [CNT_W-1:0] entry_count_q;
	logic             cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = (cfg_reg_t'(paddr[2]) == REG_ENTRY_COUNT);
	assign prdata  = cfg_sel ? {{(32-CNT_W){1'b0}}, entry_count_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			entry_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// input side
	logic             adv;
	logic             acc;
	cmd_t             in_cmd;
	logic             in_pcs;
	logic [VAL_W-1:0] in_x;
	logic [VAL_W-1:0] x_eff;
	logic [CNT_W-1:0] cnt_eff;
	logic [CNT_W-1:0] last_in;
	logic [CRD_W-1:0] coord_in;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;
	assign in_cmd   = cmd_t'(s_tuser[CMD_BIT]);
	assign in_pcs   = s_tuser[PCS_BIT];
	assign in_x     = s_tdata[X_LSB +: VAL_W];
	assign x_eff    = (in_pcs && in_x == MAX_U16) ? ONE_U115 : in_x;
	assign cnt_eff  = (entry_count_q > MAX_CNT) ? MAX_CNT : entry_count_q;
	assign last_in  = cnt_eff - CNT_W'(1);
	assign coord_in = {{CNT_W{1'b0}}, x_eff} * {{VAL_W{1'b0}}, last_in};

	// stage 1: position, pending load
	logic             v_s1;
	cmd_t             cmd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [SMP_W-1:0] sample_s1;
	logic [CRD_W-1:0] coord_s1;
	logic [CNT_W-1:0] last_s1;
	logic             ident_s1;
	logic [VAL_W-1:0] x_s1;
	logic             pcs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1    <= in_cmd;
			idx_s1    <= s_tdata[IDX_LSB +: IDX_W];
			sample_s1 <= s_tdata[SMP_LSB +: SMP_W];
			coord_s1  <= coord_in;
			last_s1   <= last_in;
			ident_s1  <= (cnt_eff == '0);
			x_s1      <= x_eff;
			pcs_s1    <= in_pcs;
		end
	end

	logic [POS_W-1:0] pos_a;
	logic [POS_W:0]   pos_b;
	logic [POS_W-1:0] last_ext;
	logic [CNT_W-1:0] a_cl;
	logic [CNT_W-1:0] b_cl;
	logic [AW-1:0]    addr_a;
	logic [AW-1:0]    addr_b;
	logic             map_s1;
	logic             ld_ok;

	assign pos_a    = coord_s1[CRD_W-1:FRC_W];
	assign pos_b    = {1'b0, pos_a} + (POS_W+1)'(1);
	assign last_ext = POS_W'(last_s1);
	assign a_cl     = (pos_a > last_ext) ? last_s1 : CNT_W'(pos_a);
	assign b_cl     = (pos_b > {1'b0, last_ext}) ? last_s1 : CNT_W'(pos_b);
	assign addr_a   = AW'(a_cl);
	assign addr_b   = AW'(b_cl);
	assign map_s1   = v_s1 && (cmd_s1 == CMD_MAP);
	assign ld_ok    = v_s1 && (cmd_s1 == CMD_LOAD)
		&& ({{(32-IDX_W){1'b0}}, idx_s1} < MAX_ENTRIES);

	// table: one write port, two registered read ports. Loads and maps touch
	// it only as they leave stage 1, so accesses stay in item order.
	logic [SMP_W-1:0] curve_mem [MAX_ENTRIES];
	logic [SMP_W-1:0] rd_a_s2;
	logic [SMP_W-1:0] rd_b_s2;

	always_ff @(posedge clk) begin
		if (adv && ld_ok) begin
			curve_mem[AW'(idx_s1)] <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && map_s1 && !ident_s1) begin
			rd_a_s2 <= curve_mem[addr_a];
			rd_b_s2 <= curve_mem[addr_b];
		end
	end

	// stage 2: blend
	logic             v_s2;
	logic [FRC_W-1:0] t_s2;
	logic             ident_s2;
	logic [VAL_W-1:0] x_s2;
	logic             pcs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= map_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2     <= coord_s1[FRC_W-1:0];
			ident_s2 <= ident_s1;
			x_s2     <= x_s1;
			pcs_s2   <= pcs_s1;
		end
	end

	logic [15:0] w_a;
	logic [31:0] prod_a;
	logic [31:0] prod_b;
	logic [31:0] blend;

	assign w_a    = 16'h8000 - {1'b0, t_s2};
	assign prod_a = {16'h0, rd_a_s2} * {16'h0, w_a};
	assign prod_b = {16'h0, rd_b_s2} * {17'h0, t_s2};
	assign blend  = prod_a + prod_b;

	// stage 3: round to 16-bit sample
	logic             v_s3;
	logic [31:0]      blend_s3;
	logic             ident_s3;
	logic [VAL_W-1:0] x_s3;
	logic             pcs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blend_s3 <= blend;
			ident_s3 <= ident_s2;
			x_s3     <= x_s2;
			pcs_s3   <= pcs_s2;
		end
	end

	logic [32:0]      rnd;
	logic [17:0]      s_full;
	logic [SMP_W-1:0] s_sat;

	assign rnd    = {1'b0, blend_s3} + 33'd16384;
	assign s_full = rnd[32:15];
	assign s_sat  = (s_full > 18'h0FFFF) ? MAX_U16 : s_full[15:0];

	// stage 4: rescale s*32768/65535 with rounding
	logic             v_s4;
	logic [SMP_W-1:0] smp_s4;
	logic             ident_s4;
	logic [VAL_W-1:0] x_s4;
	logic             pcs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s4   <= s_sat;
			ident_s4 <= ident_s3;
			x_s4     <= x_s3;
			pcs_s4   <= pcs_s3;
		end
	end

	// divide by 2^16-1: estimate with x + x/2^16, then correct by one
	logic [30:0]        num;
	logic [31:0]        est;
	logic [15:0]        q_est;
	logic [31:0]        q_prod;
	logic signed [32:0] rem;
	logic [VAL_W-1:0]   y_div;
	logic [VAL_W-1:0]   y_pre;
	logic [VAL_W-1:0]   y_fin;

	assign num    = {smp_s4, 15'h7FFF};
	assign est    = {1'b0, num} + {17'h0, num[30:16]} + 32'd1;
	assign q_est  = est[31:16];
	assign q_prod = {q_est, 16'h0} - {16'h0, q_est};
	assign rem    = $signed({2'b0, num}) - $signed({1'b0, q_prod});

	always_comb begin
		if (rem < 0) begin
			y_div = q_est - 16'd1;
		end else if (rem >= 33'sd65535) begin
			y_div = q_est + 16'd1;
		end else begin
			y_div = q_est;
		end
	end

	assign y_pre = ident_s4 ? x_s4 : y_div;
	assign y_fin = (pcs_s4 && y_pre == ONE_U115) ? MAX_U16 : y_pre;

	// output register
	logic             m_tvalid_q;
	logic [VAL_W-1:0] y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_q <= y_fin;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = y_q;

endmodule

// ----- rtl/core/stcl_checker.sv -----
// Port-level checks of the sampled tone curve interpolator, bound to the top.
// Depends on stcl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stcl_checker
	import stcl_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TUSER_W-1:0] s_tuser,  // command, pcs_xyz
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [VAL_W-1:0]     m_tdata   // y_out
);

	localparam logic [2:0] MAX_IN_FLIGHT = 3'd5;

	logic       map_in;
	logic       res_out;
	logic [2:0] pend_q;

	assign map_in  = s_tvalid && s_tready && (cmd_t'(s_tuser[CMD_BIT]) == CMD_MAP);
	assign res_out = m_tvalid && m_tready;

	// count map transactions whose result is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (map_in && !res_out) begin
			pend_q <= pend_q + 3'd1;
		end else if (res_out && !map_in) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	`ASSERT_PROP(a_valid_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
	`ASSERT_HOLD(a_data_hold, clk, arst_n, m_tvalid && !m_tready, m_tdata, "m_tdata changed")
	`ASSERT_PROP(a_ready_rule, clk, arst_n, s_tready == (!m_tvalid || m_tready), "s_tready wrong")
	`ASSERT_PROP(a_no_phantom, clk, arst_n, m_tvalid |-> pend_q != 3'd0, "result with no map")
	`ASSERT_PROP(a_depth, clk, arst_n, pend_q <= MAX_IN_FLIGHT, "too many maps in flight")

endmodule

bind sampled_tone_curve_lerp stcl_checker u_stcl_checker (.*);

// ----- sim/tone_curve_checker.sv -----
// Checker for the sampled tone curve interpolator: mirrors the table and entry_count,
// predicts each mapped value and compares it with the output stream.
// Depends on stcl_pkg; instantiated by sampled_tone_curve_lerp_tb.
module tone_curve_checker
	import stcl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_AW-1:0]     paddr,
	input  logic [31:0]           pwdata,
	input  logic [31:0]           prdata,
	input  logic                  pready,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // table_index, table_sample, x_in, zero pad
	input  logic [S_TUSER_W-1:0]  s_tuser,  // command, pcs_xyz
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [VAL_W-1:0]      m_tdata,  // y_out
	output int                    mismatch_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 4096;

	logic [SMP_W-1:0] curve_mirror [DEPTH];
	logic [CNT_W-1:0] count_mirror;
	logic [VAL_W-1:0] y_expected_q [$];

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("%0t ns: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	function automatic logic [VAL_W-1:0] tone_map(input logic [VAL_W-1:0] x_raw,
			input logic pcs);
		logic [VAL_W-1:0] x;
		logic [CNT_W-1:0] n;
		logic [IDX_W-1:0] last;
		logic [27:0]      coord;
		logic [12:0]      lo;
		logic [12:0]      hi;
		logic [14:0]      frac;
		logic [31:0]      blend;
		logic [16:0]      s;
		logic [32:0]      scaled;
		logic [VAL_W-1:0] y;
		// PCS-XYZ: full scale input stands for exactly 1.0
		x = (pcs && x_raw == MAX_U16) ? ONE_U115 : x_raw;
		n = (count_mirror > DEPTH) ? CNT_W'(DEPTH) : count_mirror;
		if (n == '0) begin
			y = x;
		end else begin
			last   = IDX_W'(n - 1'b1);
			coord  = 28'(x) * 28'(last);
			lo     = coord[27:15];
			frac   = coord[14:0];
			hi     = lo + 1'b1;
			if (lo > last) lo = 13'(last);
			if (hi > last) hi = 13'(last);
			blend  = 32'(curve_mirror[lo[IDX_W-1:0]]) * (32'd32768 - 32'(frac))
			       + 32'(curve_mirror[hi[IDX_W-1:0]]) * 32'(frac);
			s      = 17'((blend + 32'd16384) >> 15);
			if (s > 17'd65535) s = 17'd65535;
			scaled = (33'(s) * 33'd32768 + 33'd32767) / 33'd65535;
			y      = scaled[VAL_W-1:0];
		end
		// PCS-XYZ: exactly 1.0 on the output saturates to full scale
		if (pcs && y == ONE_U115) y = MAX_U16;
		return y;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_mirror = '0;
			y_expected_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready &&
			    cfg_reg_t'(paddr[CFG_AW-1:2]) == REG_ENTRY_COUNT) begin
				if (pwrite)
					count_mirror = pwdata[CNT_W-1:0];
				else if (prdata !== 32'(count_mirror))
					report("entry_count readback", 32'(count_mirror), prdata);
			end
			if (m_tvalid && m_tready) begin
				if (y_expected_q.size() == 0)
					report("y_out with nothing outstanding", 32'h0, 32'(m_tdata));
				else begin
					logic [VAL_W-1:0] want;
					want = y_expected_q.pop_front();
					if (m_tdata !== want)
						report("y_out", 32'(want), 32'(m_tdata));
				end
			end
			if (s_tvalid && s_tready) begin
				if (cmd_t'(s_tuser[CMD_BIT]) == CMD_LOAD)
					curve_mirror[s_tdata[IDX_LSB +: IDX_W]] = s_tdata[SMP_LSB +: SMP_W];
				else
					y_expected_q.push_back(tone_map(s_tdata[X_LSB +: VAL_W],
						s_tuser[PCS_BIT]));
			end
			pending = y_expected_q.size();
		end
	end

endmodule

// ----- sim/sampled_tone_curve_lerp_tb.sv -----
// Top of the tone curve testbench: clock, reset, APB writes of entry_count,
// load and map stimulus with random idling, and the final verdict.
// Depends on stcl_pkg, sampled_tone_curve_lerp and tone_curve_checker.
module sampled_tone_curve_lerp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stcl_pkg::*;

	localparam int unsigned DEPTH = 4096;

	logic                  clk;
	logic                  arst_n;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_AW-1:0]     paddr   = '0;
	logic [31:0]           pwdata  = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;  // table_index, table_sample, x_in, zero pad
	logic [S_TUSER_W-1:0]  s_tuser  = '0;  // command, pcs_xyz
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [VAL_W-1:0]      m_tdata;        // y_out

	int mismatch_count;
	int pending;
	bit tx_idle_en;
	bit rx_idle_en;
	bit hold_req;
	bit loaded [DEPTH];

	sampled_tone_curve_lerp dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	tone_curve_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatch_count(mismatch_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("simulation failed");
		$finish;
	end

	// Output side: random stall bursts, plus one long hold on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				m_tready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return SMP_W'($urandom());
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] rand_x();
		logic [VAL_W-1:0] corners [7];
		corners = '{16'h0000, 16'h0001, 16'h7FFF, ONE_U115, 16'h8001, 16'hFFFE, MAX_U16};
		if ($urandom_range(0, 5) == 0)
			return corners[$urandom_range(0, 6)];
		return VAL_W'($urandom());
	endfunction

	task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] idx,
			input logic [SMP_W-1:0] smp, input logic [VAL_W-1:0] x, input logic pcs);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({x, smp, idx});
		s_tuser  <= {pcs, cmd};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
	endtask

	task automatic send_load(input int unsigned idx, input logic [SMP_W-1:0] smp);
		send_item(CMD_LOAD, IDX_W'(idx), smp, rand_x(), 1'($urandom()));
	endtask

	task automatic send_map(input logic [VAL_W-1:0] x, input logic pcs);
		send_item(CMD_MAP, IDX_W'($urandom()), SMP_W'($urandom()), x, pcs);
	endtask

	// Load the two entries a map of x will blend, where they were never written.
	task automatic prep_map(input int unsigned eff, input logic [VAL_W-1:0] x,
			input logic pcs);
		logic [VAL_W-1:0] xe;
		int unsigned      lo;
		int unsigned      hi;
		if (eff == 0) return;
		xe = (pcs && x == MAX_U16) ? ONE_U115 : x;
		lo = (32'(xe) * (eff - 1)) >> 15;
		hi = lo + 1;
		if (lo > eff - 1) lo = eff - 1;
		if (hi > eff - 1) hi = eff - 1;
		if (!loaded[lo]) send_load(lo, rand_sample());
		if (!loaded[hi]) send_load(hi, rand_sample());
	endtask

	// Drop valid and wait until every mapped value is back and the pipe has drained.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_ENTRY_COUNT, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_count(input int unsigned value);
		settle();
		// upper bits are junk; only the low CNT_W bits are kept
		apb_access(1'b1, {19'($urandom()), CNT_W'(value)});
		@(posedge clk);
		apb_access(1'b0, '0);
	endtask

	task automatic run_phase(input int unsigned count_val, input int n_items, input bit hold);
		int unsigned      eff;
		logic [VAL_W-1:0] x;
		logic             pcs;
		set_count(count_val);
		eff = (count_val > DEPTH) ? DEPTH : count_val;
		for (int i = 0; i < n_items; i++) begin
			if (hold && i == 10) hold_req = 1'b1;
			if ($urandom_range(0, 9) < 3) begin
				// favor rewriting live entries when the curve is short
				if (eff > 0 && eff < DEPTH && $urandom_range(0, 1) == 1)
					send_load($urandom_range(0, eff - 1), rand_sample());
				else
					send_load($urandom_range(0, DEPTH - 1), rand_sample());
			end else begin
				x   = rand_x();
				pcs = 1'($urandom());
				prep_map(eff, x, pcs);
				send_map(x, pcs);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_req   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset, including both PCS-XYZ substitutions
		send_map(16'h0000, 1'b0);
		send_map(MAX_U16, 1'b0);
		send_map(MAX_U16, 1'b1);
		send_map(ONE_U115, 1'b1);
		send_map(ONE_U115, 1'b0);

		// single entry curve returns entry 0, rescaled to u1.15
		set_count(1);
		send_load(0, MAX_U16);
		send_map(16'h3039, 1'b1);
		send_map(16'h3039, 1'b0);
		send_load(0, 16'h0000);
		send_map(MAX_U16, 1'b1);

		// two entry ramp: midpoint, exact 1.0, top clamp
		set_count(2);
		send_load(0, 16'h0000);
		send_load(1, MAX_U16);
		send_load(DEPTH - 1, 16'hA5A5);
		send_map(16'h4000, 1'b0);
		send_map(ONE_U115, 1'b1);
		send_map(MAX_U16, 1'b0);
		send_map(MAX_U16, 1'b1);
		send_map(16'h0000, 1'b1);

		run_phase(0, 60, 1'b0);
		run_phase(2, 70, 1'b1);
		run_phase(3, 60, 1'b0);
		run_phase($urandom_range(4, 64), 70, 1'b0);
		run_phase(1, 60, 1'b0);
		run_phase($urandom_range(65, 300), 70, 1'b0);
		// count beyond the table depth acts as full depth
		run_phase(8191, 60, 1'b0);
		run_phase(4096, 60, 1'b0);
		run_phase(4097, 60, 1'b0);
		run_phase($urandom_range(0, 8191), 60, 1'b0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_phase($urandom_range(2, 4096), 100, 1'b0);

		settle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
